>>> sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int PRIO_W      = 16;
	localparam int FILL_W      = 8;
	localparam int STATUS_W    = 2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Broadcast command seen by every cell in the same cycle
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t item;
	} cell_cmd_t;

endpackage
`default_nettype wire

>>> sv/spq_req_if.sv
// Request channel: valid/ready with the insert or remove payload.
`default_nettype none
interface spq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [spq_pkg::DATA_W-1:0]   item_data;
	logic        [spq_pkg::PRIO_W-1:0]   item_priority;

	modport source (output valid, req_type, item_data, item_priority, input ready);
	modport sink   (input valid, req_type, item_data, item_priority, output ready);
endinterface
`default_nettype wire

>>> sv/spq_rsp_if.sv
// Response channel: valid/ready with status, head data and fill count.
`default_nettype none
interface spq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic        [spq_pkg::STATUS_W-1:0]  status;
	logic signed [spq_pkg::DATA_W-1:0]    head_data;
	logic        [spq_pkg::FILL_W-1:0]    fill_count;

	modport source (output valid, status, head_data, fill_count, input ready);
	modport sink   (input valid, status, head_data, fill_count, output ready);
endinterface
`default_nettype wire

>>> sv/spq_cell.sv
// One slot of the sorted shift chain: compare, hold, take left or take right.
`default_nettype none
module spq_cell (
	input  wire logic                      clk,
	input  wire spq_pkg::cell_cmd_t        cmd,
	input  wire logic [spq_pkg::CNT_W-1:0] count,
	input  wire logic [spq_pkg::IDX_W-1:0] idx,
	input  wire logic                      left_gt,
	input  wire spq_pkg::entry_t           left_entry,
	input  wire spq_pkg::entry_t           right_entry,
	output spq_pkg::entry_t                entry,
	output logic                           gt
);

	spq_pkg::entry_t entry_q;
	logic            occ;

	// Slot is occupied when its index lies below the fill count
	assign occ   = count > spq_pkg::CNT_W'(idx);
	// Empty slots rank after any new entry; ties stay ahead of it
	assign gt    = !occ || (entry_q.prio > cmd.item.prio);
	assign entry = entry_q;

	// Shift right on insert past the slot, shift left on remove
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt) begin
				entry_q <= cmd.item;
			end
		end else if (cmd.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

>>> sv/sorted_priority_queue.sv
// Top level: request decode, cell chain, fill count and response register.
//
//  channel | dir | payload                                   | accepted when
//  req     | in  | req_type, item_data, item_priority        | valid && ready
//  rsp     | out | status, head_data, fill_count             | valid && ready
//
// One request per cycle unless rsp stalls: every cell compares against the
// broadcast priority and moves in the same cycle, so the chain never iterates.
// The response is registered and appears in the cycle after its request is taken.
// req.ready is high while the response register is empty or being drained.
// Reset clears the fill count and the response valid; slot contents are
// not cleared, only slots below the fill count are ever read.
`default_nettype none
module sorted_priority_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int D = spq_pkg::QUEUE_DEPTH;

	logic [spq_pkg::CNT_W-1:0]    count_q;
	logic [spq_pkg::CNT_W-1:0]    count_next;
	logic                         rsp_valid_q;
	logic [spq_pkg::STATUS_W-1:0] status_q;
	logic [spq_pkg::DATA_W-1:0]   head_q;
	logic [spq_pkg::FILL_W-1:0]   fill_q;

	logic                         fire;
	logic                         full;
	logic                         empty;
	logic [spq_pkg::STATUS_W-1:0] status_next;
	spq_pkg::cell_cmd_t           cmd;

	spq_pkg::entry_t              cell_entry [D];
	logic                         cell_gt    [D];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign full      = count_q == spq_pkg::CNT_W'(D);
	assign empty     = count_q == '0;

	// Decode the beat into a chain command and next count
	always_comb begin
		cmd.ins       = 1'b0;
		cmd.rem       = 1'b0;
		cmd.item.data = req.item_data;
		cmd.item.prio = req.item_priority;
		count_next    = count_q;
		status_next   = spq_pkg::ST_DONE;
		if (req.req_type == spq_pkg::REQ_INSERT) begin
			if (full) begin
				status_next = spq_pkg::ST_FULL;
			end else begin
				cmd.ins    = fire;
				count_next = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_next = spq_pkg::ST_EMPTY;
			end else begin
				cmd.rem    = fire;
				count_next = count_q - 1'b1;
			end
		end
	end

	// Chain of slots, head at index zero
	for (genvar i = 0; i < D; i++) begin : g_cell
		spq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.count       (count_q),
			.idx         (spq_pkg::IDX_W'(i)),
			.left_gt     ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
			.left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
			.right_entry (cell_entry[(i == D - 1) ? i : i + 1]),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i])
		);
	end

	// Advance the fill count and the response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the response payload with the beat
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_next;
			head_q   <= cmd.rem ? cell_entry[0].data : '0;
			fill_q   <= spq_pkg::FILL_W'(count_next);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.head_data  = head_q;
	assign rsp.fill_count = fill_q;

endmodule
`default_nettype wire

>>> tb/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: shadow queue, random traffic, backpressure.
`timescale 1ns / 1ps
module tb_sorted_priority_queue;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int HOLD_AT_RESULT = 350;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic                       kind;
		logic [spq_pkg::DATA_W-1:0] data;
		logic [spq_pkg::PRIO_W-1:0] prio;
		bit                         drain;
	} pq_req_t;

	typedef struct {
		logic [spq_pkg::STATUS_W-1:0] status;
		logic [spq_pkg::DATA_W-1:0]   head_data;
		logic [spq_pkg::FILL_W-1:0]   fill_count;
	} pq_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the sorted store
	logic [spq_pkg::DATA_W-1:0] pq_data [spq_pkg::QUEUE_DEPTH];
	logic [spq_pkg::PRIO_W-1:0] pq_prio [spq_pkg::QUEUE_DEPTH];
	int pq_count = 0;

	pq_req_t     pending [$];
	pq_outcome_t outcome_q [$];

	int n_insert = 0, n_full = 0, n_remove = 0, n_empty = 0, peak_fill = 0;
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;

	// Driver and monitor bookkeeping
	int  gap_left = 0, quiet_tx = 0;
	int  stall_left = 0, quiet_rx = 0, hold_left = 0;
	bit  hold_done = 0;
	logic offer, take;
	pq_req_t nxt;
	pq_outcome_t exp_res;

	always #5 clk = ~clk;

	// Apply one request to the shadow queue and return the result it must give
	function automatic pq_outcome_t pq_apply(logic kind, logic [spq_pkg::DATA_W-1:0] data,
			logic [spq_pkg::PRIO_W-1:0] prio);
		pq_outcome_t res;
		int pos;
		res.status = spq_pkg::ST_DONE;
		res.head_data = '0;
		if (kind == spq_pkg::REQ_INSERT) begin
			n_insert++;
			if (pq_count >= spq_pkg::QUEUE_DEPTH) begin
				res.status = spq_pkg::ST_FULL;
				n_full++;
			end else begin
				// shift larger keys back, ties stay ahead of the newcomer
				pos = pq_count;
				while (pos > 0 && pq_prio[pos-1] > prio) begin
					pq_data[pos] = pq_data[pos-1];
					pq_prio[pos] = pq_prio[pos-1];
					pos--;
				end
				pq_data[pos] = data;
				pq_prio[pos] = prio;
				pq_count++;
				if (pq_count > peak_fill) peak_fill = pq_count;
			end
		end else begin
			n_remove++;
			if (pq_count == 0) begin
				res.status = spq_pkg::ST_EMPTY;
				n_empty++;
			end else begin
				res.head_data = pq_data[0];
				for (int i = 0; i + 1 < pq_count; i++) begin
					pq_data[i] = pq_data[i+1];
					pq_prio[i] = pq_prio[i+1];
				end
				pq_count--;
			end
		end
		res.fill_count = spq_pkg::FILL_W'(pq_count);
		return res;
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long pause
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio(int mode);
		case (mode)
			1: return spq_pkg::PRIO_W'($urandom_range(0, 7));
			2: return $urandom_range(0, 1) ? spq_pkg::PRIO_W'($urandom_range(0, 1))
					: spq_pkg::PRIO_W'($urandom_range(65534, 65535));
			default: return spq_pkg::PRIO_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic add_req(logic kind, logic [spq_pkg::DATA_W-1:0] data,
			logic [spq_pkg::PRIO_W-1:0] prio);
		pq_req_t it;
		it.kind = kind;
		it.data = data;
		it.prio = prio;
		it.drain = 0;
		pending.push_back(it);
	endtask

	task automatic add_drain();
		pq_req_t it;
		it.kind = spq_pkg::REQ_INSERT;
		it.data = '0;
		it.prio = '0;
		it.drain = 1;
		pending.push_back(it);
	endtask

	// Request driver: offer items from the pending list, predict on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= spq_pkg::REQ_INSERT;
			req_ch.item_data <= '0;
			req_ch.item_priority <= '0;
		end else begin
			offer = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				outcome_q.push_back(pq_apply(req_ch.req_type, req_ch.item_data,
						req_ch.item_priority));
				offer = 1'b0;
				if (quiet_tx > 0) begin
					quiet_tx--;
					gap_left = 0;
				end else begin
					gap_left = gap_len();
					if ($urandom_range(0, 49) == 0) quiet_tx = $urandom_range(30, 90);
				end
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0) begin
					if (pending[0].drain) begin
						// hold until every outstanding result is back
						if (outcome_q.size() == 0) pending.delete(0);
					end else begin
						nxt = pending[0];
						pending.delete(0);
						req_ch.req_type <= nxt.kind;
						req_ch.item_data <= nxt.data;
						req_ch.item_priority <= nxt.prio;
						offer = 1'b1;
					end
				end
			end
			req_ch.valid <= offer;
		end
	end

	// Response monitor: check each beat against the oldest expectation, drive ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result: status %0d head_data %h fill %0d",
								$realtime, rsp_ch.status, rsp_ch.head_data, rsp_ch.fill_count);
				end else begin
					exp_res = outcome_q.pop_front();
					if (rsp_ch.status !== exp_res.status
							|| rsp_ch.head_data !== exp_res.head_data
							|| rsp_ch.fill_count !== exp_res.fill_count) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch: status %0d/%0d head_data %h/%h fill %0d/%0d (exp/got)",
									$realtime, exp_res.status, rsp_ch.status,
									exp_res.head_data, rsp_ch.head_data,
									exp_res.fill_count, rsp_ch.fill_count);
					end
				end
				if (quiet_rx > 0) begin
					quiet_rx--;
				end else begin
					stall_left = gap_len();
					if ($urandom_range(0, 49) == 0) quiet_rx = $urandom_range(30, 90);
				end
			end
			// long hold once so the block backs up into the request side
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
				hold_done = 1;
				hold_left = HOLD_CYCLES;
				take = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				take = 1'b1;
			end
			rsp_ch.ready <= take;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, outcome_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Build the stimulus, release reset, wait for the traffic to finish
	initial begin
		int n_rand;
		int rnd;
		int len;
		int ins_pct;
		int mode;

		// Directed: empty remove, field extremes, ties, drain in order
		add_req(spq_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		add_req(spq_pkg::REQ_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
		add_req(spq_pkg::REQ_INSERT, 32'h8000_0000, 16'h0000);
		add_req(spq_pkg::REQ_INSERT, 32'h0000_0000, 16'h8000);
		add_req(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 16'h8000);
		add_req(spq_pkg::REQ_INSERT, 32'h1234_5678, 16'h0000);
		add_req(spq_pkg::REQ_INSERT, 32'hA5A5_A5A5, 16'h5A5A);
		add_req(spq_pkg::REQ_INSERT, 32'h5A5A_5A5A, 16'hA5A5);
		add_req(spq_pkg::REQ_INSERT, 32'h0000_0001, 16'hFFFE);
		add_req(spq_pkg::REQ_INSERT, 32'hFFFF_FFFE, 16'h0001);
		for (int i = 0; i < 10; i++)
			add_req(spq_pkg::REQ_REMOVE, $urandom,
					spq_pkg::PRIO_W'($urandom_range(0, 65535)));
		add_req(spq_pkg::REQ_REMOVE, 32'h0000_0000, 16'h0000);
		add_drain();

		// Random rounds: fill past full, drain past empty, then mixed traffic
		n_rand = 0;
		rnd = 0;
		while (n_rand < RANDOM_ITEMS) begin
			case (rnd % 3)
				0: begin len = 240; ins_pct = 90; end
				1: begin len = 240; ins_pct = 12; end
				default: begin len = 150; ins_pct = 50; end
			endcase
			mode = $urandom_range(0, 2);
			for (int i = 0; i < len; i++)
				add_req(($urandom_range(0, 99) < ins_pct) ? spq_pkg::REQ_INSERT
						: spq_pkg::REQ_REMOVE, $urandom, pick_prio(mode));
			add_drain();
			n_rand += len;
			rnd++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || req_ch.valid || outcome_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d inserts (%0d refused on a full queue) and %0d removes (%0d on empty),",
				n_insert, n_full, n_remove, n_empty);
		$display("peak fill %0d of %0d, %0d results checked", peak_fill,
				spq_pkg::QUEUE_DEPTH, results_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
